FILE: design/buddy_block_allocator_top_assert.svh
// Assertion macros used by the allocator checker.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BBA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BBA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bba_pkg.sv
// Shared constants and types of the buddy block allocator.
package bba_pkg;

    localparam int LEVELS      = 15;
    localparam int REGION_BITS = 23;
    localparam int LV_W        = 4;
    localparam int OFF_W       = REGION_BITS;
    localparam int LVI_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int KW          = LEVELS - 1;
    localparam int WORD_LG     = 5;
    localparam int WORD_BITS   = 1 << WORD_LG;
    localparam int KX          = (KW > WORD_LG) ? KW : WORD_LG;
    localparam int DEPTH       = (LEVELS > WORD_LG) ?
                                 (1 << (LEVELS - WORD_LG)) + WORD_LG - 1 : LEVELS;
    localparam int AW          = $clog2(DEPTH);
    localparam int CNT_W       = LEVELS;
    localparam int SH_W        = $clog2(REGION_BITS + 1);

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_NOMEM = 1'b1;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC1 = 2'd2;
    localparam logic [1:0] CNT_DEC2 = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [LVI_W-1:0] lvl;
    } cnt_upd_t;

endpackage

FILE: design/bba_ram.sv
// Generic single-write, single-read word RAM with registered read data.
module bba_ram #(
    parameter int DEPTH = 1028,
    parameter int WIDTH = 32,
    parameter int AW    = 11
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/bba_lvl_cnt.sv
// Per-level free block counters and nearest non-empty level search.
module bba_lvl_cnt import bba_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cnt_upd_t         upd,
    input  logic [LVI_W-1:0] q_lvl,
    output logic             found,
    output logic [LVI_W-1:0] src
);

    logic [CNT_W-1:0] cnt_reg [LEVELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < LEVELS; j++) begin
                cnt_reg[j] <= (j == 0) ? CNT_W'(1) : '0;
            end
        end else begin
            case (upd.op)
                CNT_INC:  cnt_reg[upd.lvl] <= cnt_reg[upd.lvl] + CNT_W'(1);
                CNT_DEC1: cnt_reg[upd.lvl] <= cnt_reg[upd.lvl] - CNT_W'(1);
                CNT_DEC2: cnt_reg[upd.lvl] <= cnt_reg[upd.lvl] - CNT_W'(2);
                default: ;
            endcase
        end
    end

    // Nearest non-empty level at or above the requested size (highest index wins last).
    always_comb begin
        found = 1'b0;
        src   = '0;
        for (int j = 0; j < LEVELS; j++) begin
            if ((j <= int'(q_lvl)) && (cnt_reg[j] != '0)) begin
                found = 1'b1;
                src   = LVI_W'(j);
            end
        end
    end

endmodule

FILE: design/buddy_block_allocator_top.sv
// Buddy block allocator: sequencer, word modify unit and output register.
//
// Buddy allocator over a region of 2^23 offsets in 15 size levels. Each input
// beat is an allocate (mode 0, level) or a free (mode 1, level, block_offset),
// and each gives exactly one result beat. The free map lives in a 1028 x 32 bit
// RAM, one bit per block, each level packed into its own run of words; a
// per-level free count picks the source level without touching the RAM. After
// reset a clearing pass writes every RAM word, and s_ready stays low until it
// is done. The block takes one beat at a time and all work goes through one
// read-modify-write unit on the single RAM port, so timing is set by RAM
// accesses. An allocate scans its source level word by word (up to 512 words
// at level 14), takes the lowest free block, and marks the upper half free at
// each level split; a free, while its buddy is free, clears both halves and
// moves to the parent, then marks the resulting block free; a bad level or an
// allocate with no memory goes straight to the result. The result then moves
// into the output register; that move waits while the previous result is
// still untaken. Ready returns in the cycle after the move, and the next
// request beat can be accepted while the output register holds its result
// until taken. Frees are not checked: free only blocks you hold. Misaligned
// free offsets drop their low bits.
module buddy_block_allocator_top import bba_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_mode,
    input  logic [LV_W-1:0]  s_level,
    input  logic [OFF_W-1:0] s_block_offset,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [OFF_W-1:0] m_granted_offset,
    output logic             m_status
);

    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DEC      = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_CHK = 4'd4;
    localparam logic [3:0] S_SPLIT    = 4'd5;
    localparam logic [3:0] S_RMW_RD   = 4'd6;
    localparam logic [3:0] S_RMW_MOD  = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    localparam logic MODE_ALLOC = 1'b0;
    localparam int   AW1        = AW + 1;
    localparam int   WIDE       = OFF_W + KX;

    // Word address of block k at level l.
    function automatic logic [AW-1:0] word_addr(input logic [LVI_W-1:0] l,
                                                input logic [KX-1:0] k);
        logic [AW1-1:0] base;
        logic [AW1-1:0] word;
        if (int'(l) < WORD_LG) begin
            base = AW1'(l);
        end else begin
            base = (AW1'(1) << (int'(l) - WORD_LG)) + AW1'(WORD_LG - 1);
        end
        word = AW1'(k >> WORD_LG);
        return AW'(base + word);
    endfunction

    function automatic logic [WORD_LG-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [WORD_LG-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = WORD_LG'(i);
            end
        end
        return idx;
    endfunction

    logic [3:0]           state_reg, state_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic                 mode_reg, mode_next;
    logic [LV_W-1:0]      lvin_reg, lvin_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic [LVI_W-1:0]     lvl_reg, lvl_next;
    logic [LVI_W-1:0]     cur_l_reg, cur_l_next;
    logic [KX-1:0]        k_reg, k_next;
    logic [OFF_W-1:0]     res_off_reg, res_off_next;
    logic                 res_st_reg, res_st_next;
    logic                 m_valid_reg, m_valid_next;
    logic [OFF_W-1:0]     m_off_reg, m_off_next;
    logic                 m_st_reg, m_st_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    cnt_upd_t             upd;
    logic                 lvl_found;
    logic [LVI_W-1:0]     lvl_src;

    logic                 lv_ok;
    logic [LVI_W-1:0]     lv_i;
    logic [SH_W-1:0]      sh;
    logic [KX-1:0]        kmask;
    logic [WIDE-1:0]      wide_dn;
    logic [WIDE-1:0]      wide_up;
    logic [KX-1:0]        free_k;
    logic [OFF_W-1:0]     alloc_off;
    logic [KX-1:0]        rmw_k;
    logic [WORD_LG-1:0]   bi;
    logic [WORD_BITS-1:0] onehot;
    logic [WORD_BITS-1:0] budhot;
    logic                 old_bit;
    logic                 bud_bit;
    logic [WORD_LG-1:0]   low;

    bba_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bba_lvl_cnt u_lvl_cnt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (upd),
        .q_lvl   (lv_i),
        .found   (lvl_found),
        .src     (lvl_src)
    );

    // Request decode: block index from offset, offset from block index.
    assign lv_ok   = int'(lvin_reg) < LEVELS;
    assign lv_i    = LVI_W'(lvin_reg);
    assign sh      = (int'(lvin_reg) <= REGION_BITS) ?
                     SH_W'(REGION_BITS - int'(lvin_reg)) : '0;
    assign kmask   = ~({KX{1'b1}} << lvin_reg);
    assign wide_dn = {{KX{1'b0}}, off_reg} >> sh;
    assign free_k  = wide_dn[KX-1:0] & kmask;
    assign wide_up = {{OFF_W{1'b0}}, k_reg} << sh;
    assign alloc_off = wide_up[OFF_W-1:0];

    // Split writes the upper half (odd index); free targets the block itself.
    assign rmw_k   = (mode_reg == MODE_ALLOC) ? (k_reg | KX'(1)) : k_reg;
    assign bi      = rmw_k[WORD_LG-1:0];
    assign onehot  = WORD_BITS'(1) << bi;
    assign budhot  = WORD_BITS'(1) << (bi ^ WORD_LG'(1));
    assign old_bit = |(ram_rdata & onehot);
    assign bud_bit = |(ram_rdata & budhot);
    assign low     = lowest_set(ram_rdata);

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_granted_offset = m_off_reg;
    assign m_status         = m_st_reg;

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        mode_next     = mode_reg;
        lvin_next     = lvin_reg;
        off_next      = off_reg;
        lvl_next      = lvl_reg;
        cur_l_next    = cur_l_reg;
        k_next        = k_reg;
        res_off_next  = res_off_reg;
        res_st_next   = res_st_reg;
        m_valid_next  = m_valid_reg;
        m_off_next    = m_off_reg;
        m_st_next     = m_st_reg;
        ram_we        = 1'b0;
        ram_waddr     = word_addr(cur_l_reg, rmw_k);
        ram_raddr     = word_addr(cur_l_reg, rmw_k);
        ram_wdata     = ram_rdata | onehot;
        upd.op        = CNT_NONE;
        upd.lvl       = cur_l_reg;

        // Drop the result once the downstream side takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = (clr_addr_reg == '0) ? WORD_BITS'(1) : '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_mode;
                    lvin_next  = s_level;
                    off_next   = s_block_offset;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                lvl_next     = lv_i;
                res_off_next = '0;
                res_st_next  = STATUS_OK;
                if (!lv_ok) begin
                    res_st_next = (mode_reg == MODE_ALLOC) ? STATUS_NOMEM : STATUS_OK;
                    state_next  = S_OUT;
                end else if (mode_reg == MODE_ALLOC) begin
                    if (lvl_found) begin
                        cur_l_next = lvl_src;
                        k_next     = '0;
                        state_next = S_SCAN_RD;
                    end else begin
                        res_st_next = STATUS_NOMEM;
                        state_next  = S_OUT;
                    end
                end else begin
                    cur_l_next = lv_i;
                    k_next     = free_k;
                    state_next = S_RMW_RD;
                end
            end
            S_SCAN_RD: begin
                ram_raddr  = word_addr(cur_l_reg, k_reg);
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                ram_waddr = word_addr(cur_l_reg, k_reg);
                if (ram_rdata != '0) begin
                    // Take the lowest free block of this level.
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata & ~(WORD_BITS'(1) << low);
                    upd.op     = CNT_DEC1;
                    k_next     = (k_reg & ~KX'(WORD_BITS - 1)) | KX'(low);
                    state_next = S_SPLIT;
                end else begin
                    k_next     = k_reg + KX'(WORD_BITS);
                    state_next = S_SCAN_RD;
                end
            end
            S_SPLIT: begin
                if (cur_l_reg == lvl_reg) begin
                    res_off_next = alloc_off;
                    state_next   = S_OUT;
                end else begin
                    // Advance one level down: keep the lower half, free the upper.
                    cur_l_next = cur_l_reg + LVI_W'(1);
                    k_next     = k_reg << 1;
                    state_next = S_RMW_RD;
                end
            end
            S_RMW_RD: begin
                state_next = S_RMW_MOD;
            end
            S_RMW_MOD: begin
                ram_we = 1'b1;
                if ((mode_reg != MODE_ALLOC) && (cur_l_reg != '0) && bud_bit) begin
                    // Merge: clear both halves and mark the parent next.
                    ram_wdata  = ram_rdata & ~onehot & ~budhot;
                    upd.op     = old_bit ? CNT_DEC2 : CNT_DEC1;
                    cur_l_next = cur_l_reg - LVI_W'(1);
                    k_next     = k_reg >> 1;
                    state_next = S_RMW_RD;
                end else begin
                    ram_wdata = ram_rdata | onehot;
                    upd.op    = old_bit ? CNT_NONE : CNT_INC;
                    state_next = (mode_reg == MODE_ALLOC) ? S_SPLIT : S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_off_next   = res_off_reg;
                    m_st_next    = res_st_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        lvin_reg    <= lvin_next;
        off_reg     <= off_next;
        lvl_reg     <= lvl_next;
        cur_l_reg   <= cur_l_next;
        k_reg       <= k_next;
        res_off_reg <= res_off_next;
        res_st_reg  <= res_st_next;
        m_off_reg   <= m_off_next;
        m_st_reg    <= m_st_next;
    end

endmodule

FILE: design/bba_chk.sv
// Port-level checker for the buddy block allocator, bound to the top level.
`include "buddy_block_allocator_top_assert.svh"

module bba_chk import bba_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             s_mode,
    input logic [LV_W-1:0]  s_level,
    input logic [OFF_W-1:0] s_block_offset,
    input logic             m_valid,
    input logic             m_ready,
    input logic [OFF_W-1:0] m_granted_offset,
    input logic             m_status
);

    // A stalled result beat holds.
    `BBA_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_granted_offset) && $stable(m_status), "result beat changed while stalled")

    // A failed allocate reports offset zero.
    `BBA_ASSERT_IMP(a_nomem_zero, aclk, aresetn, m_valid && (m_status == STATUS_NOMEM), m_granted_offset == '0, "no-memory result with nonzero offset")

    // Ready drops right after a free beat is taken.
    `BBA_ASSERT_NXT(a_free_ok, aclk, aresetn, s_valid && s_ready && s_mode, !s_ready, "request accepted back to back")

    // Ready drops right after an out-of-range allocate beat is taken.
    `BBA_ASSERT_NXT(a_range_busy, aclk, aresetn, s_valid && s_ready && !s_mode && (int'(s_level) >= LEVELS), !s_ready, "out-of-range allocate left ready high")

endmodule

bind buddy_block_allocator_top bba_chk u_bba_chk (.*);
